FILE: rtl/core/bbs_pkg.sv
// Package for the bouncing body step block: sequencer states, register
// indexes, datapath widths and the saturation and angle wrap helpers.
// No dependencies.
package bbs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GRAV,
    ST_MUL1,
    ST_DIV,
    ST_CORR,
    ST_MUL2,
    ST_SCALE,
    ST_MOVE,
    ST_FIN
  } state_e;

  // configuration register indexes
  localparam logic [2:0] REG_FALL_ACCEL    = 3'd0;
  localparam logic [2:0] REG_BOUNCE_FACTOR = 3'd1;
  localparam logic [2:0] REG_BODY_RADIUS   = 3'd2;
  localparam logic [2:0] REG_FLOOR_LEVEL   = 3'd3;
  localparam logic [2:0] REG_SPIN_STEP     = 3'd4;
  localparam logic [2:0] REG_START_HEIGHT  = 3'd5;

  // register reset values
  localparam logic [20:0] FALL_ACCEL_RST    = 21'd655;
  localparam logic [16:0] BOUNCE_FACTOR_RST = 17'd52429;
  localparam logic [30:0] BODY_RADIUS_RST   = 31'd65536;

  // datapath widths
  localparam int unsigned GAP_W     = 34;  // height - radius - floor
  localparam int unsigned DIV_STEPS = 34;  // quotient bits, bounded by |gap|
  localparam int unsigned PROD_W    = 55;  // 34 x 21 product
  localparam int unsigned CNT_W     = 6;

  // 360 degrees in Q16.16
  localparam logic signed [26:0] FULL_TURN     = 27'sd23592960;
  localparam logic signed [26:0] NEG_FULL_TURN = -27'sd23592960;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic [31:0] sat32(logic signed [39:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // truncated remainder by a full turn; |sum| stays below three turns
  function automatic logic [25:0] wrap_angle(logic signed [26:0] s);
    logic signed [26:0] r;
    r = s;
    if (r >= FULL_TURN) begin
      r = r - FULL_TURN;
    end
    if (r >= FULL_TURN) begin
      r = r - FULL_TURN;
    end
    if (r <= NEG_FULL_TURN) begin
      r = r + FULL_TURN;
    end
    if (r <= NEG_FULL_TURN) begin
      r = r + FULL_TURN;
    end
    return r[25:0];
  endfunction

endpackage

FILE: rtl/core/bouncing_body_step.sv
// Bouncing body step: vertical gravity/bounce update plus spin angle per tick.
// Depends on bbs_pkg (states, register indexes, sat32, wrap_angle).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one frame tick: advance_i
//   and restart_i. A transfer happens when in_valid_i is high and in_stall_o
//   low. The block takes one tick at a time; in_stall_o stays high from the
//   transfer until that tick's result has been loaded into the output register.
//   Output channel (out_valid_o / out_stall_i) carries height, speed, angle and
//   the resting flag after the tick. The output register holds a finished
//   result while the receiver stalls; the next tick is accepted meanwhile and
//   its result waits in the final state until the register frees up.
//   After the input transfer, a restart goes straight to the final state; a
//   plain move or a resting body passes through the move state; free fall or
//   landing passes through the gravity and move states. A bounce adds the
//   shift-subtract divider, one quotient bit per cycle over 34 bits, plus two
//   passes through the shared multiplier.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
//   next edge and must only happen while the block is idle.
//   Reset: asynchronous, active low; state returns to zero height, speed and
//   angle, not resting, and configuration registers return to their defaults.
module bouncing_body_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // tick input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        advance_i,
  input  logic        restart_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] height_out_o,
  output logic [31:0] speed_out_o,
  output logic [25:0] angle_out_o,
  output logic        resting_out_o
);

  bbs_pkg::state_e state_q, state_d;

  // configuration registers
  logic [20:0] fall_accel_q, fall_accel_d;
  logic [16:0] bounce_factor_q, bounce_factor_d;
  logic [30:0] body_radius_q, body_radius_d;
  logic [31:0] floor_level_q, floor_level_d;
  logic [25:0] spin_step_q, spin_step_d;
  logic [31:0] start_height_q, start_height_d;

  // body state
  logic [31:0] height_q, height_d;
  logic [31:0] speed_q, speed_d;
  logic [25:0] angle_q, angle_d;
  logic        rest_q, rest_d;

  // bounce datapath
  logic [bbs_pkg::GAP_W-1:0]     op_q, op_d;        // multiplier operand
  logic [bbs_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic [31:0]                   div_q, div_d;      // divisor, -speed
  logic [31:0]                   rem_q, rem_d;
  logic [bbs_pkg::DIV_STEPS-1:0] quo_q, quo_d;
  logic [bbs_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          neg_q, neg_d;      // gap below zero
  logic                          res_neg_q, res_neg_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] height_out_q, speed_out_q;
  logic [25:0] angle_out_q;
  logic        resting_out_q;

  logic in_xfer;
  logic out_load;

  // ---------------------------------------------------------------------
  // Gravity decision terms, from the current body state and configuration
  // ---------------------------------------------------------------------
  logic        [32:0]              spd_ext;
  logic        [32:0]              spd_mag;
  logic        [32:0]              spd_neg;
  logic        [32:0]              neg_g;
  logic signed [bbs_pkg::GAP_W-1:0] gap;
  logic        [bbs_pkg::GAP_W-1:0] gap_mag;
  logic signed [bbs_pkg::GAP_W:0]   gap_plus;
  logic                             rest_hit;
  logic                             touching;
  logic                             fast_down;
  logic        [31:0]               free_val;

  assign spd_ext = {speed_q[31], speed_q};
  assign spd_neg = 33'd0 - spd_ext;
  assign spd_mag = spd_ext[32] ? spd_neg : spd_ext;
  assign neg_g   = 33'd0 - {12'd0, fall_accel_q};

  assign gap = {{2{height_q[31]}}, height_q} - {3'd0, body_radius_q}
             - {{2{floor_level_q[31]}}, floor_level_q};
  assign gap_mag  = gap[bbs_pkg::GAP_W-1] ? (34'd0 - gap) : gap;
  assign gap_plus = {gap[bbs_pkg::GAP_W-1], gap} + {{3{speed_q[31]}}, speed_q};

  assign rest_hit  = (spd_mag < {12'd0, fall_accel_q}) && (gap <= 34'sd0);
  assign touching  = gap_plus <= 35'sd0;
  assign fast_down = $signed(spd_ext) < $signed(neg_g);
  assign free_val  = bbs_pkg::sat32($signed({{7{spd_ext[32]}}, spd_ext})
                                    - $signed({19'd0, fall_accel_q}));

  // ---------------------------------------------------------------------
  // Shared multiplier: |gap| * g for the correction, |w| * restitution
  // ---------------------------------------------------------------------
  logic [20:0]                mul_b;
  logic [bbs_pkg::PROD_W-1:0] product;

  assign mul_b   = (state_q == bbs_pkg::ST_MUL1) ? fall_accel_q : {4'd0, bounce_factor_q};
  assign product = op_q * mul_b;

  // ---------------------------------------------------------------------
  // Shift-subtract divider step, one quotient bit per cycle
  // ---------------------------------------------------------------------
  logic [32:0] trial;
  logic [33:0] diff;
  logic        fits;

  assign trial = {rem_q, quo_q[bbs_pkg::DIV_STEPS-1]};
  assign diff  = {1'b0, trial} - {2'd0, div_q};
  assign fits  = ~diff[33];

  // ---------------------------------------------------------------------
  // Correction and restitution terms
  // ---------------------------------------------------------------------
  logic [35:0] quo_ext;
  logic [35:0] corr;
  logic [35:0] w_val;
  logic [35:0] w_mag;
  logic [39:0] scaled;
  logic [39:0] scaled_signed;

  assign quo_ext = {2'd0, quo_q};
  assign corr    = neg_q ? (36'd0 - quo_ext) : quo_ext;
  assign w_val   = {{4{speed_q[31]}}, speed_q} - corr;
  assign w_mag   = w_val[35] ? (36'd0 - w_val) : w_val;

  // (-w * restitution) / 1.0, truncated toward zero
  assign scaled        = {1'b0, prod_q[bbs_pkg::PROD_W-1:16]};
  assign scaled_signed = res_neg_q ? (40'd0 - scaled) : scaled;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            state_d = bbs_pkg::ST_FIN;
          end else if (advance_i && !rest_q) begin
            state_d = bbs_pkg::ST_GRAV;
          end else begin
            state_d = bbs_pkg::ST_MOVE;
          end
        end
      end
      bbs_pkg::ST_GRAV: begin
        if (!rest_hit && touching && fast_down) begin
          state_d = bbs_pkg::ST_MUL1;
        end else begin
          state_d = bbs_pkg::ST_MOVE;
        end
      end
      bbs_pkg::ST_MUL1: state_d = bbs_pkg::ST_DIV;
      bbs_pkg::ST_DIV: begin
        if (cnt_q == bbs_pkg::CNT_W'(bbs_pkg::DIV_STEPS - 1)) begin
          state_d = bbs_pkg::ST_CORR;
        end
      end
      bbs_pkg::ST_CORR:  state_d = bbs_pkg::ST_MUL2;
      bbs_pkg::ST_MUL2:  state_d = bbs_pkg::ST_SCALE;
      bbs_pkg::ST_SCALE: state_d = bbs_pkg::ST_MOVE;
      bbs_pkg::ST_MOVE:  state_d = bbs_pkg::ST_FIN;
      bbs_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = bbs_pkg::ST_IDLE;
        end
      end
      default: state_d = bbs_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      bbs_pkg::ST_IDLE: in_stall_o = 1'b0;
      bbs_pkg::ST_FIN:  out_load   = !out_valid_q || !out_stall_i;
      default: begin
        in_stall_o = 1'b1;
        out_load   = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_comb begin
    fall_accel_d    = fall_accel_q;
    bounce_factor_d = bounce_factor_q;
    body_radius_d   = body_radius_q;
    floor_level_d   = floor_level_q;
    spin_step_d     = spin_step_q;
    start_height_d  = start_height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbs_pkg::REG_FALL_ACCEL:    fall_accel_d    = cfg_wdata_i[20:0];
        bbs_pkg::REG_BOUNCE_FACTOR: bounce_factor_d = cfg_wdata_i[16:0];
        bbs_pkg::REG_BODY_RADIUS:   body_radius_d   = cfg_wdata_i[30:0];
        bbs_pkg::REG_FLOOR_LEVEL:   floor_level_d   = cfg_wdata_i;
        bbs_pkg::REG_SPIN_STEP:     spin_step_d     = cfg_wdata_i[25:0];
        bbs_pkg::REG_START_HEIGHT:  start_height_d  = cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  always_comb begin
    height_d  = height_q;
    speed_d   = speed_q;
    angle_d   = angle_q;
    rest_d    = rest_q;
    op_d      = op_q;
    prod_d    = prod_q;
    div_d     = div_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    res_neg_d = res_neg_q;

    unique case (state_q)
      bbs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (restart_i) begin
            height_d = start_height_q;
            speed_d  = 32'd0;
            angle_d  = 26'd0;
            rest_d   = 1'b0;
          end else if (advance_i) begin
            angle_d = bbs_pkg::wrap_angle({angle_q[25], angle_q}
                                          + {spin_step_q[25], spin_step_q});
          end
        end
      end
      bbs_pkg::ST_GRAV: begin
        // operands for a possible bounce
        op_d  = gap_mag;
        neg_d = gap[bbs_pkg::GAP_W-1];
        div_d = spd_neg[31:0];
        if (rest_hit) begin
          rest_d  = 1'b1;
          speed_d = 32'd0;
        end else if (!touching) begin
          speed_d = free_val;
        end
        // touching but slow: speed holds
      end
      bbs_pkg::ST_MUL1: begin
        // quotient < |gap| < 2^34, so the top bits are below the divisor
        rem_d = {11'd0, product[bbs_pkg::PROD_W-1:bbs_pkg::DIV_STEPS]};
        quo_d = product[bbs_pkg::DIV_STEPS-1:0];
        cnt_d = '0;
      end
      bbs_pkg::ST_DIV: begin
        rem_d = fits ? diff[31:0] : trial[31:0];
        quo_d = {quo_q[bbs_pkg::DIV_STEPS-2:0], fits};
        cnt_d = cnt_q + 1'b1;
      end
      bbs_pkg::ST_CORR: begin
        op_d      = w_mag[bbs_pkg::GAP_W-1:0];
        res_neg_d = !w_val[35] && (w_val != 36'd0);
      end
      bbs_pkg::ST_MUL2: begin
        prod_d = product;
      end
      bbs_pkg::ST_SCALE: begin
        speed_d = bbs_pkg::sat32($signed(scaled_signed));
      end
      bbs_pkg::ST_MOVE: begin
        height_d = bbs_pkg::sat32($signed({{8{height_q[31]}}, height_q})
                                  + $signed({{8{speed_q[31]}}, speed_q}));
      end
      bbs_pkg::ST_FIN: ;
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= bbs_pkg::ST_IDLE;
      fall_accel_q    <= bbs_pkg::FALL_ACCEL_RST;
      bounce_factor_q <= bbs_pkg::BOUNCE_FACTOR_RST;
      body_radius_q   <= bbs_pkg::BODY_RADIUS_RST;
      floor_level_q   <= 32'd0;
      spin_step_q     <= 26'd0;
      start_height_q  <= 32'd0;
      height_q        <= 32'd0;
      speed_q         <= 32'd0;
      angle_q         <= 26'd0;
      rest_q          <= 1'b0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      fall_accel_q    <= fall_accel_d;
      bounce_factor_q <= bounce_factor_d;
      body_radius_q   <= body_radius_d;
      floor_level_q   <= floor_level_d;
      spin_step_q     <= spin_step_d;
      start_height_q  <= start_height_d;
      height_q        <= height_d;
      speed_q         <= speed_d;
      angle_q         <= angle_d;
      rest_q          <= rest_d;
      cnt_q           <= cnt_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    prod_q    <= prod_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    res_neg_q <= res_neg_d;
    if (out_load) begin
      height_out_q  <= height_q;
      speed_out_q   <= speed_q;
      angle_out_q   <= angle_q;
      resting_out_q <= rest_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign height_out_o  = height_out_q;
  assign speed_out_o   = speed_out_q;
  assign angle_out_o   = angle_out_q;
  assign resting_out_o = resting_out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a resting body never moves
  a_rest_still : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_q |-> (speed_q == 32'd0))
    else $error("resting body has nonzero speed");

  // angle magnitude stays below a full turn
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed({angle_q[25], angle_q}) < bbs_pkg::FULL_TURN) &&
    ($signed({angle_q[25], angle_q}) > bbs_pkg::NEG_FULL_TURN))
    else $error("spin angle out of range");

  // divider partial remainder always below the divisor
  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbs_pkg::ST_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  // a bounce divides only by a speed faster than gravity
  a_div_dvsr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbs_pkg::ST_DIV) |-> (div_q > {11'd0, fall_accel_q}))
    else $error("bounce divisor not above fall_accel");

  // a restart lands the start state right away
  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && restart_i) |=>
      (state_q == bbs_pkg::ST_FIN) && (height_q == start_height_q) &&
      (speed_q == 32'd0) && !rest_q)
    else $error("restart did not restore start state");

endmodule
